// ----- hw/rtl/day_count_to_calendar_date_assert.svh -----
// assertion helpers for the date converter
`ifndef DAY_COUNT_TO_CALENDAR_DATE_ASSERT_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_ASSERT_SVH

// same-cycle implication, off during reset
`define DCD_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define DCD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dcd_pkg.sv -----
`timescale 1ns / 1ps

package dcd_pkg;

  localparam int unsigned EpochYear  = 1978;
  localparam int unsigned YearSpan   = 180;
  localparam int unsigned DayCountW  = 16;
  localparam int unsigned YearIdxW   = 8;
  localparam int unsigned OffW       = 17;
  localparam int unsigned RemW       = 9;
  localparam int unsigned DayW       = 5;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned YearW      = 12;
  localparam int unsigned MonthCount = 12;

  // year index estimate: count * 2865 / 2^20, never above the true index, at most one below
  localparam int unsigned RecipW     = 12;
  localparam int unsigned RecipShift = 20;
  localparam logic [RecipW-1:0] YearRecip = 12'd2865;

  // 2100 is the only year in range with index 2 mod 4 that is not leap
  localparam logic [YearIdxW-1:0] CenturySkipIdx = 8'd122;

  typedef logic [OffW-1:0] year_off_arr_t [0:YearSpan];
  typedef logic [RemW-1:0] month_cum_arr_t [0:MonthCount-1];

  typedef struct packed {
    logic [YearIdxW-1:0] year_idx;
    logic [RemW-1:0]     rem;
  } year_rem_t;

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // days before the start of each year, counted from the epoch year
  function automatic year_off_arr_t build_year_off();
    year_off_arr_t tab;
    int unsigned   acc;
    acc = 0;
    for (int i = 0; i <= YearSpan; i++) begin
      tab[i] = OffW'(acc);
      acc = acc + (is_leap(EpochYear + i) ? 366 : 365);
    end
    return tab;
  endfunction

  localparam year_off_arr_t YearOff = build_year_off();

  // days before each month in a common year
  localparam month_cum_arr_t MonthCum = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

// ----- hw/rtl/day_count_to_calendar_date.sv -----
`timescale 1ns / 1ps
// day count to calendar date converter
// input channel: in_valid / in_ready carry in_day_count, a 16-bit day count
// where 1 january 1978 is day 1; a count of 0 gives day 0 of january 1978
// result channel: out_valid / out_ready carry out_day_of_month,
// out_month_number (january is 1) and out_year_number (1978 to 2157)
// five register stages: year estimate by multiply, year offset table read,
// year correction, month compare, day subtract
// throughput is one item per cycle through the five-stage pipeline while
// out_ready stays high
// each stage holds its item while the next one is full, so a stalled receiver
// backs the pipeline up stage by stage; in_ready falls only once all five
// stages hold items, and nothing is dropped or repeated
// reset (rst_n low, synchronous) empties every stage; no clearing pass is needed
`include "day_count_to_calendar_date_assert.svh"

module day_count_to_calendar_date (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dcd_pkg::DayCountW-1:0]     in_day_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dcd_pkg::DayW-1:0]          out_day_of_month,
  output logic [dcd_pkg::MonthW-1:0]        out_month_number,
  output logic [dcd_pkg::YearW-1:0]         out_year_number
);

  logic                               yr_valid;
  logic                               yr_ready;
  dcd_pkg::year_rem_t                 yr_data;

  // stage 4: month and leap flag
  logic                               s4_valid_r;
  logic [dcd_pkg::YearW-1:0]          s4_year_r;
  logic [dcd_pkg::MonthW-1:0]         s4_month_r;
  logic [dcd_pkg::RemW-1:0]           s4_rem_r;
  logic                               s4_leap_r;
  logic [dcd_pkg::MonthW-1:0]         s4_month_nxt;
  logic                               s4_leap_nxt;
  logic                               s4_ready;

  // stage 5: output register
  logic                               s5_valid_r;
  logic [dcd_pkg::DayW-1:0]           s5_day_r;
  logic [dcd_pkg::MonthW-1:0]         s5_month_r;
  logic [dcd_pkg::YearW-1:0]          s5_year_r;
  logic [dcd_pkg::DayW-1:0]           s5_day_nxt;
  logic [dcd_pkg::MonthW-1:0]         prev_month;
  logic [dcd_pkg::RemW-1:0]           day_full;
  logic                               feb_adj;
  logic                               s5_ready;

  dcd_year_split u_year_split (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_day_count (in_day_count),
    .yr_valid     (yr_valid),
    .yr_ready     (yr_ready),
    .yr_data      (yr_data)
  );

  assign s5_ready = !s5_valid_r || out_ready;
  assign s4_ready = !s4_valid_r || s5_ready;
  assign yr_ready = s4_ready;

  // month boundaries are monotonic, so the highest one passed picks the month
  always_comb begin
    logic [dcd_pkg::RemW-1:0] bound;
    s4_leap_nxt  = (yr_data.year_idx[1:0] == 2'd2) &&
                   (yr_data.year_idx != dcd_pkg::CenturySkipIdx);
    s4_month_nxt = dcd_pkg::MonthW'(1);
    for (int m = 1; m < dcd_pkg::MonthCount; m++) begin
      bound = dcd_pkg::MonthCum[m] + dcd_pkg::RemW'(s4_leap_nxt && (m >= 2));
      if (yr_data.rem > bound) begin
        s4_month_nxt = dcd_pkg::MonthW'(m + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_r <= yr_valid;
    end
    if (s4_ready && yr_valid) begin
      s4_year_r  <= dcd_pkg::YearW'(dcd_pkg::EpochYear) + dcd_pkg::YearW'(yr_data.year_idx);
      s4_month_r <= s4_month_nxt;
      s4_rem_r   <= yr_data.rem;
      s4_leap_r  <= s4_leap_nxt;
    end
  end

  always_comb begin
    prev_month = s4_month_r - 1'b1;
    feb_adj    = s4_leap_r && (s4_month_r > dcd_pkg::MonthW'(2));
    day_full   = s4_rem_r - dcd_pkg::MonthCum[prev_month] - dcd_pkg::RemW'(feb_adj);
    s5_day_nxt = day_full[dcd_pkg::DayW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (s5_ready) begin
      s5_valid_r <= s4_valid_r;
    end
    if (s5_ready && s4_valid_r) begin
      s5_day_r   <= s5_day_nxt;
      s5_month_r <= s4_month_r;
      s5_year_r  <= s4_year_r;
    end
  end

  assign out_valid        = s5_valid_r;
  assign out_day_of_month = s5_day_r;
  assign out_month_number = s5_month_r;
  assign out_year_number  = s5_year_r;

  // input backs up only when the whole pipeline is full and the output stalls
  `DCD_ASSERT_NOW(a_stall_source, clk, rst_n, !in_ready, out_valid && !out_ready, "in_ready low without output stall")
  // day zero only comes from count zero, which lands in january
  `DCD_ASSERT_NOW(a_day_zero_jan, clk, rst_n, out_valid && (out_day_of_month == 5'd0), (out_month_number == 4'd1) && (out_year_number == 12'd1978), "day zero outside january 1978")
  // february never runs past 29
  `DCD_ASSERT_NOW(a_feb_len, clk, rst_n, out_valid && (out_month_number == 4'd2), out_day_of_month <= 5'd29, "february day out of range")
  // a transfer in occupies the first stage in the next cycle
  `DCD_ASSERT_NEXT(a_fill, clk, rst_n, in_valid && in_ready, u_year_split.s1_valid_r, "pipeline lost an input")

endmodule

// ----- hw/rtl/dcd_year_split.sv -----
`timescale 1ns / 1ps

module dcd_year_split (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dcd_pkg::DayCountW-1:0]       in_day_count,
  output logic                                yr_valid,
  input  logic                                yr_ready,
  output dcd_pkg::year_rem_t                  yr_data
);

  localparam int unsigned ProdW = dcd_pkg::DayCountW + dcd_pkg::RecipW;

  // stage 1: year index estimate
  logic                             s1_valid_r;
  logic [dcd_pkg::DayCountW-1:0]    s1_cnt_r;
  logic [dcd_pkg::YearIdxW-1:0]     s1_est_r;
  logic [ProdW-1:0]                 prod;
  logic                             s1_ready;

  // stage 2: year offsets around the estimate
  logic                             s2_valid_r;
  logic [dcd_pkg::DayCountW-1:0]    s2_cnt_r;
  logic [dcd_pkg::YearIdxW-1:0]     s2_est_r;
  logic [dcd_pkg::OffW-1:0]         s2_off_lo_r;
  logic [dcd_pkg::OffW-1:0]         s2_off_hi_r;
  logic [dcd_pkg::YearIdxW-1:0]     est_inc;
  logic                             s2_ready;

  // stage 3: corrected year and day of year
  logic                             s3_valid_r;
  dcd_pkg::year_rem_t               s3_data_r;
  dcd_pkg::year_rem_t               s3_data_nxt;
  logic [dcd_pkg::OffW-1:0]         cnt_ext;
  logic                             take_hi;
  logic [dcd_pkg::OffW-1:0]         rem_full;
  logic                             s3_ready;

  assign s3_ready = !s3_valid_r || yr_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  assign prod = ProdW'(in_day_count) * ProdW'(dcd_pkg::YearRecip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_cnt_r <= in_day_count;
      s1_est_r <= prod[dcd_pkg::RecipShift +: dcd_pkg::YearIdxW];
    end
  end

  assign est_inc = s1_est_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_ready && s1_valid_r) begin
      s2_cnt_r    <= s1_cnt_r;
      s2_est_r    <= s1_est_r;
      s2_off_lo_r <= dcd_pkg::YearOff[s1_est_r];
      s2_off_hi_r <= dcd_pkg::YearOff[est_inc];
    end
  end

  always_comb begin
    cnt_ext               = dcd_pkg::OffW'(s2_cnt_r);
    take_hi               = cnt_ext > s2_off_hi_r;
    rem_full              = cnt_ext - (take_hi ? s2_off_hi_r : s2_off_lo_r);
    s3_data_nxt.year_idx  = s2_est_r + dcd_pkg::YearIdxW'(take_hi);
    s3_data_nxt.rem       = rem_full[dcd_pkg::RemW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
    if (s3_ready && s2_valid_r) begin
      s3_data_r <= s3_data_nxt;
    end
  end

  assign yr_valid = s3_valid_r;
  assign yr_data  = s3_data_r;

endmodule

// ----- bench/calendar_date_checker.sv -----
`timescale 1ns / 1ps

module calendar_date_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [dcd_pkg::DayCountW-1:0] in_day_count,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [dcd_pkg::DayW-1:0]   out_day_of_month,
  input  logic [dcd_pkg::MonthW-1:0] out_month_number,
  input  logic [dcd_pkg::YearW-1:0]  out_year_number,
  output int                         mismatch_count,
  output int                         dates_outstanding,
  output int                         dates_checked
);
  import dcd_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [DayCountW-1:0] count;
    logic [DayW-1:0]      day;
    logic [MonthW-1:0]    month;
    logic [YearW-1:0]     year;
  } cal_date_t;

  cal_date_t dates_due[$];

  function automatic bit is_leap_year(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned mon, int unsigned yr);
    case (mon)
      4, 6, 9, 11: return 30;
      2: return is_leap_year(yr) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  function automatic cal_date_t date_from_day_count(logic [DayCountW-1:0] count);
    cal_date_t   d;
    int unsigned left;
    int unsigned yr;
    int unsigned mon;
    int unsigned len;
    left = count;
    yr   = EpochYear;
    mon  = 1;
    // strip whole years; a leftover of 366 in a leap year is 31 december
    while (left > 365 && !(left == 366 && is_leap_year(yr))) begin
      left = left - (is_leap_year(yr) ? 366 : 365);
      yr++;
    end
    len = days_in_month(mon, yr);
    while (mon < 12 && left > len) begin
      left = left - len;
      mon++;
      len = days_in_month(mon, yr);
    end
    d.count = count;
    d.day   = DayW'(left);
    d.month = MonthW'(mon);
    d.year  = YearW'(yr);
    return d;
  endfunction

  always @(posedge clk) begin
    cal_date_t due;
    if (!rst_n) begin
      mismatch_count    <= 0;
      dates_outstanding <= 0;
      dates_checked     <= 0;
    end else begin
      if (in_valid && in_ready) begin
        dates_due.push_back(date_from_day_count(in_day_count));
      end
      if (out_valid && out_ready) begin
        if (dates_due.size() == 0) begin
          if (mismatch_count < ReportLimit) begin
            $display("%0t: result transfer with nothing pending: day %0d month %0d year %0d",
                     $time, out_day_of_month, out_month_number, out_year_number);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          due = dates_due.pop_front();
          dates_checked <= dates_checked + 1;
          if (out_day_of_month !== due.day || out_month_number !== due.month ||
              out_year_number !== due.year) begin
            if (mismatch_count < ReportLimit) begin
              $display("%0t: count %0d expected %0d/%0d/%0d got %0d/%0d/%0d (d/m/y)",
                       $time, due.count, due.day, due.month, due.year,
                       out_day_of_month, out_month_number, out_year_number);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      dates_outstanding <= dates_due.size();
    end
  end

endmodule

// ----- bench/day_count_to_calendar_date_tb.sv -----
`timescale 1ns / 1ps

module day_count_to_calendar_date_tb;
  import dcd_pkg::*;

  localparam int RandomCounts  = 1780;
  localparam int QuietLimit    = 2000;
  localparam int HoldCycles    = 64;
  localparam int HoldAfter     = 300;
  localparam int DrainCycles   = 10;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [DayCountW-1:0] in_day_count;
  logic                 out_valid;
  logic                 out_ready;
  logic [DayW-1:0]      out_day_of_month;
  logic [MonthW-1:0]    out_month_number;
  logic [YearW-1:0]     out_year_number;

  int mismatch_count;
  int dates_outstanding;
  int dates_checked;
  int counts_sent;
  int quiet_cycles;
  bit no_idle;

  // year ends, leap days, 2000 and 2100 boundaries, top of range, bit patterns
  logic [DayCountW-1:0] landmark_counts[$] = '{
    16'd0, 16'd1, 16'd31, 16'd32, 16'd59, 16'd60, 16'd365, 16'd366,
    16'd790, 16'd791, 16'd1096, 16'd1097, 16'd8035, 16'd8036, 16'd8095,
    16'd8096, 16'd8401, 16'd44560, 16'd44619, 16'd44620, 16'd44925,
    16'd65534, 16'd65535, 16'h5555, 16'hAAAA
  };

  day_count_to_calendar_date DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_day_count     (in_day_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_day_of_month (out_day_of_month),
    .out_month_number (out_month_number),
    .out_year_number  (out_year_number)
  );

  calendar_date_checker date_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_day_count      (in_day_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_day_of_month  (out_day_of_month),
    .out_month_number  (out_month_number),
    .out_year_number   (out_year_number),
    .mismatch_count    (mismatch_count),
    .dates_outstanding (dates_outstanding),
    .dates_checked     (dates_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d dates pending",
                 QuietLimit, dates_outstanding);
        $display("day_count_to_calendar_date regression: fail");
        $finish;
      end
    end
  end

  task automatic send_day_count(input logic [DayCountW-1:0] count);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_day_count <= count;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    counts_sent++;
    @(negedge clk);
  endtask

  initial begin
    logic [DayCountW-1:0] count;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_day_count = '0;
    counts_sent  = 0;
    no_idle      = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (landmark_counts[i]) send_day_count(landmark_counts[i]);

    for (int i = 0; i < RandomCounts; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: count = DayCountW'($urandom_range(0, 1500));
        1: count = DayCountW'($urandom_range(64000, 65535));
        default: count = DayCountW'($urandom_range(0, 65535));
      endcase
      send_day_count(count);
    end
    in_valid <= 1'b0;

    while (dates_outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d day counts, %0d of them landmarks (year ends, leap days, top of range)",
             counts_sent, landmark_counts.size());
    $display("%0d dates compared; results held back %0d cycles once while input kept coming",
             dates_checked, HoldCycles);
    if (mismatch_count == 0 && dates_outstanding == 0) begin
      $display("day_count_to_calendar_date regression: pass");
    end else begin
      $display("day_count_to_calendar_date regression: fail");
    end
    $finish;
  end

  initial begin
    int gap;
    int taken;
    bit held;
    out_ready = 1'b0;
    taken     = 0;
    held      = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      // one long stall so the pipeline fills and in_ready drops
      if (!held && taken >= HoldAfter) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

endmodule
